// ----- src/servo_short_packet_framer_defines.svh -----
// ============================================================================
// Servo short packet framer assertion macros
// Shared assertion shorthands for the checker of the packet framer.
// ============================================================================
`ifndef SERVO_SHORT_PACKET_FRAMER_DEFINES_SVH
`define SERVO_SHORT_PACKET_FRAMER_DEFINES_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define SSPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds through reset.
`define SSPF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/sspf_pkg.sv -----
// ============================================================================
// Servo short packet framer package
// Types, packet constants and the byte selection function of the framer.
// ============================================================================
package sspf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] HDR0_BYTE   = 8'hFA;
   localparam logic [7:0] HDR1_BYTE   = 8'hAF;
   localparam logic [7:0] FLAGS_BYTE  = 8'h00;
   localparam logic [7:0] ADDR_TORQUE = 8'h24;
   localparam logic [7:0] ADDR_GOAL   = 8'h1E;
   localparam logic [7:0] LEN_TORQUE  = 8'h01;
   localparam logic [7:0] LEN_GOAL    = 8'h02;
   localparam logic [7:0] COUNT_BYTE  = 8'h01;

   typedef enum logic [0:0] {
      OP_TORQUE = 1'b0,
      OP_GOAL   = 1'b1
   } op_type;

   typedef logic [3:0] byte_idx_type;

   // Byte positions within a packet.
   localparam byte_idx_type IDX_HDR0       = 4'd0;
   localparam byte_idx_type IDX_HDR1       = 4'd1;
   localparam byte_idx_type IDX_ID         = 4'd2;
   localparam byte_idx_type IDX_FLAGS      = 4'd3;
   localparam byte_idx_type IDX_ADDR       = 4'd4;
   localparam byte_idx_type IDX_LEN        = 4'd5;
   localparam byte_idx_type IDX_COUNT      = 4'd6;
   localparam byte_idx_type IDX_DATA_LO    = 4'd7;
   localparam byte_idx_type IDX_DATA_HI    = 4'd8;
   localparam byte_idx_type IDX_CKS_TORQUE = 4'd8;
   localparam byte_idx_type IDX_CKS_GOAL   = 4'd9;

   typedef struct packed {
      op_type     op;
      logic [7:0] servo_id;
      logic [7:0] data_lo;
      logic [7:0] data_hi;
      logic [7:0] checksum;
   } cmd_type;

   function automatic logic [7:0] addr_of(input op_type op);
      addr_of = (op == OP_GOAL) ? ADDR_GOAL : ADDR_TORQUE;
   endfunction

   function automatic logic [7:0] len_of(input op_type op);
      len_of = (op == OP_GOAL) ? LEN_GOAL : LEN_TORQUE;
   endfunction

   function automatic byte_idx_type last_idx_of(input op_type op);
      last_idx_of = (op == OP_GOAL) ? IDX_CKS_GOAL : IDX_CKS_TORQUE;
   endfunction

   function automatic logic [7:0] packet_byte(input cmd_type cmd, input byte_idx_type idx);
      logic [7:0] b;
      b = cmd.checksum;
      case (idx)
         IDX_HDR0:    b = HDR0_BYTE;
         IDX_HDR1:    b = HDR1_BYTE;
         IDX_ID:      b = cmd.servo_id;
         IDX_FLAGS:   b = FLAGS_BYTE;
         IDX_ADDR:    b = addr_of(cmd.op);
         IDX_LEN:     b = len_of(cmd.op);
         IDX_COUNT:   b = COUNT_BYTE;
         IDX_DATA_LO: b = cmd.data_lo;
         IDX_DATA_HI: b = (cmd.op == OP_GOAL) ? cmd.data_hi : cmd.checksum;
         default:     b = cmd.checksum;
      endcase
      packet_byte = b;
   endfunction

endpackage

// ----- src/sspf_front.sv -----
// ============================================================================
// Servo short packet framer front end
// Accepts commands, classifies them and works out the packet checksum.
// ============================================================================
module sspf_front
   import sspf_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // servo_id [7:0], value [23:8]
   input  logic [0:0]  req_tuser,   // op [0]
   input  logic        q_full,
   output logic        push,
   output cmd_type     push_cmd
);

   op_type            op;
   logic [7:0]        servo_id;
   logic signed [15:0] value;
   logic [7:0]        data_hi;

   assign op       = op_type'(req_tuser[0]);
   assign servo_id = req_tdata[7:0];
   assign value    = signed'(req_tdata[23:8]);

   // A torque command carries only the low byte, so the high byte drops out of the sum.
   assign data_hi  = (op == OP_GOAL) ? value[15:8] : 8'h00;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_cmd.op       = op;
      push_cmd.servo_id = servo_id;
      push_cmd.data_lo  = value[7:0];
      push_cmd.data_hi  = value[15:8];
      push_cmd.checksum = servo_id ^ FLAGS_BYTE ^ addr_of(op) ^ len_of(op) ^ COUNT_BYTE
                          ^ value[7:0] ^ data_hi;
   end

endmodule

// ----- src/sspf_queue.sv -----
// ============================================================================
// Servo short packet framer command queue
// Short first-in first-out store of classified commands between the two halves.
// ============================================================================
module sspf_queue
   import sspf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    q_full,
   output logic    q_valid,
   output cmd_type q_head
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign q_head  = mem_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/sspf_back.sv -----
// ============================================================================
// Servo short packet framer back end
// Serialises one queued command into packet bytes through an output register.
// ============================================================================
module sspf_back
   import sspf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // tx_byte [7:0]
   output logic       rsp_tlast
);

   cmd_type      cur_ff, cur_in;
   logic         cur_valid_ff, cur_valid_in;
   byte_idx_type idx_ff, idx_in;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_last_ff, out_last_in;
   logic         advance, emit, cur_last;

   assign advance  = !out_valid_ff || rsp_tready;
   assign emit     = advance && cur_valid_ff;
   assign cur_last = (idx_ff == last_idx_of(cur_ff.op));
   // The next command is taken in the same cycle as the checksum of the current one.
   assign pop      = q_valid && (!cur_valid_ff || (emit && cur_last));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = advance ? cur_valid_ff : out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_byte_in = packet_byte(cur_ff, idx_ff);
         out_last_in = cur_last;
         idx_in      = idx_ff + 1'b1;
         if (cur_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         idx_in       = IDX_HDR0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= IDX_HDR0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- src/servo_short_packet_framer.sv -----
// ============================================================================
// Servo short packet framer
// Turns servo commands into short packets, one byte per output item.
// ============================================================================
// Each accepted command becomes a packet of 9 bytes (torque enable) or 10 bytes
// (goal position), sent one byte per cycle while rsp_tready is high, with tlast
// on the closing XOR checksum. A command occupies the byte serialiser in the back
// end until its checksum byte is sent, and packets follow one another without gaps
// while the consumer keeps rsp_tready high. The front end computes the checksum on
// acceptance and places the command in a short queue, so further commands are taken
// while a packet is still being sent, until the queue is full.
module servo_short_packet_framer
   import sspf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // servo_id [7:0], value [23:8]
   input  logic [0:0]  req_tuser,   // op [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte [7:0]
   output logic        rsp_tlast
);

   logic    q_full, q_valid, push, pop;
   cmd_type push_cmd, q_head;

   sspf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sspf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_head   (q_head)
   );

   sspf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/sspf_checker.sv -----
// ============================================================================
// Servo short packet framer checker
// Watches the result port for packet framing and handshake slips.
// ============================================================================
`include "servo_short_packet_framer_defines.svh"

module sspf_checker
   import sspf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Position of the next item within the current packet.
   logic [3:0] beat_ff, beat_in;
   logic       rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      beat_in = beat_ff;
      if (rsp_fire) begin
         beat_in = rsp_tlast ? 4'd0 : beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 4'd0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   `SSPF_ASSERT(stall_holds_item, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result item changed")
   `SSPF_ASSERT_ALWAYS(reset_clears_output, reset |=> !rsp_tvalid, "result valid after reset")
   `SSPF_ASSERT(header_bytes, rsp_tvalid && (beat_ff == 4'd0 || beat_ff == 4'd1) |-> rsp_tdata == ((beat_ff == 4'd0) ? HDR0_BYTE : HDR1_BYTE) && !rsp_tlast, "packet does not open with the header")
   `SSPF_ASSERT(packet_length, rsp_tvalid && rsp_tlast |-> beat_ff == 4'd8 || beat_ff == 4'd9, "packet ended at the wrong length")
   `SSPF_ASSERT(packet_not_too_long, rsp_tvalid && beat_ff == 4'd9 |-> rsp_tlast, "packet ran past ten bytes")

endmodule

bind servo_short_packet_framer sspf_checker u_checker (.*);
